// ===== src/gtt_pkg.sv =====
// Shared types, codes and character constants for the grammar text tokenizer.
package gtt_pkg;

    // Scanner modes; codes above MODE_HALT are never entered and behave as halted.
    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_SYMBOL  = 3'd1,
        MODE_COMMENT = 3'd2,
        MODE_STRING  = 3'd3,
        MODE_ESCAPE  = 3'd4,
        MODE_HALT    = 3'd5
    } scan_mode_t;

    // Token kinds as reported on the result channel.
    typedef enum logic [3:0] {
        TK_ERROR     = 4'd0,
        TK_SYMBOL    = 4'd1,
        TK_STRING    = 4'd2,
        TK_OPEN      = 4'd3,
        TK_CLOSE     = 4'd4,
        TK_STAR      = 4'd5,
        TK_PLUS      = 4'd6,
        TK_QUESTION  = 4'd7,
        TK_EQUALS    = 4'd8,
        TK_PIPE      = 4'd9,
        TK_SEMICOLON = 4'd10,
        TK_END       = 4'd11
    } token_kind_t;

    // Result beat sorts.
    localparam logic OUT_TEXT = 1'b0;
    localparam logic OUT_DONE = 1'b1;

    // Characters the scanner recognises.
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_HASH      = 8'h23;
    localparam logic [7:0] CH_OPEN      = 8'h28;
    localparam logic [7:0] CH_CLOSE     = 8'h29;
    localparam logic [7:0] CH_STAR      = 8'h2A;
    localparam logic [7:0] CH_PLUS      = 8'h2B;
    localparam logic [7:0] CH_SEMICOLON = 8'h3B;
    localparam logic [7:0] CH_EQUALS    = 8'h3D;
    localparam logic [7:0] CH_QUESTION  = 8'h3F;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_LOWER_N   = 8'h6E;
    localparam logic [7:0] CH_PIPE      = 8'h7C;

    // Widest line or column counter the block supports.
    localparam int unsigned COUNT_MAX_WIDTH = 32;

    // Result queue depth and its index and fill widths.
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_IDX_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // One input beat.
    typedef struct packed {
        logic [7:0] char_in;
        logic       end_mark;
    } input_t;

    // One result beat.
    typedef struct packed {
        logic        out_kind;
        token_kind_t token_kind;
        logic [7:0]  text_byte;
        logic [15:0] line_number;
        logic [15:0] column_number;
        logic        last_result;
    } result_t;

    // Results produced by one scanned character, handed to the queue.
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    // Punctuation lookup; TK_ERROR means the byte is not punctuation.
    function automatic token_kind_t punct_kind(input logic [7:0] ch);
        token_kind_t kind;
        unique case (ch)
            CH_OPEN:      kind = TK_OPEN;
            CH_CLOSE:     kind = TK_CLOSE;
            CH_STAR:      kind = TK_STAR;
            CH_PLUS:      kind = TK_PLUS;
            CH_QUESTION:  kind = TK_QUESTION;
            CH_EQUALS:    kind = TK_EQUALS;
            CH_PIPE:      kind = TK_PIPE;
            CH_SEMICOLON: kind = TK_SEMICOLON;
            default:      kind = TK_ERROR;
        endcase
        return kind;
    endfunction

    function automatic logic is_letter(input logic [7:0] ch);
        return ((ch >= 8'h61) && (ch <= 8'h7A)) || ((ch >= 8'h41) && (ch <= 8'h5A));
    endfunction

    function automatic logic is_digit(input logic [7:0] ch);
        return (ch >= 8'h30) && (ch <= 8'h39);
    endfunction

endpackage

// ===== src/gtt_scan.sv =====
// Scanner: mode and position registers plus the per-character decode logic.
module gtt_scan #(
    parameter int unsigned LINE_WIDTH   = 16,
    parameter int unsigned COLUMN_WIDTH = 16
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           advance,
    input  gtt_pkg::input_t beat,
    output gtt_pkg::push_t push
);
    import gtt_pkg::*;

    scan_mode_t              mode_reg, mode_next;
    logic [LINE_WIDTH-1:0]   line_reg, line_next;
    logic [COLUMN_WIDTH-1:0] col_reg, col_next;

    logic [COUNT_MAX_WIDTH-1:0] line_wide;
    logic [COUNT_MAX_WIDTH-1:0] col_wide;
    logic [15:0]                line_sat;
    logic [15:0]                col_sat;

    logic        consume;
    logic [7:0]  ch;

    // Outcome of treating the character as if between tokens.
    result_t     idle_res;
    logic        idle_emit;
    logic        idle_consume;
    scan_mode_t  idle_mode;
    token_kind_t pk;

    result_t     res0;
    result_t     res1;
    logic [1:0]  res_count;

    function automatic result_t mk_result(input logic kind, input token_kind_t tk,
                                          input logic [7:0] byte_val,
                                          input logic [15:0] pl, input logic [15:0] pc);
        result_t r;
        r.out_kind      = kind;
        r.token_kind    = tk;
        r.text_byte     = byte_val;
        r.line_number   = pl;
        r.column_number = pc;
        r.last_result   = 1'b0;
        return r;
    endfunction

    assign ch = beat.char_in;

    // Reported positions saturate at the 16-bit field maximum.
    assign line_wide = COUNT_MAX_WIDTH'(line_reg);
    assign col_wide  = COUNT_MAX_WIDTH'(col_reg);
    assign line_sat  = (line_wide > COUNT_MAX_WIDTH'(16'hFFFF)) ? 16'hFFFF : line_wide[15:0];
    assign col_sat   = (col_wide > COUNT_MAX_WIDTH'(16'hFFFF)) ? 16'hFFFF : col_wide[15:0];

    // Handling of a character when no token is open.
    always_comb begin
        pk           = punct_kind(ch);
        idle_res     = mk_result(OUT_DONE, TK_ERROR, 8'h00, line_sat, col_sat);
        idle_emit    = 1'b0;
        idle_consume = 1'b1;
        idle_mode    = MODE_IDLE;
        if ((ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_CR) || (ch == CH_LF)) begin
            idle_emit = 1'b0;
        end else if (ch == CH_HASH) begin
            idle_mode = MODE_COMMENT;
        end else if (is_letter(ch)) begin
            idle_res  = mk_result(OUT_TEXT, TK_SYMBOL, ch, line_sat, col_sat);
            idle_emit = 1'b1;
            idle_mode = MODE_SYMBOL;
        end else if (ch == CH_QUOTE) begin
            idle_mode = MODE_STRING;
        end else if (pk != TK_ERROR) begin
            idle_res  = mk_result(OUT_DONE, pk, 8'h00, line_sat, col_sat);
            idle_emit = 1'b1;
        end else begin
            // Unknown character: report and halt without consuming it.
            idle_emit    = 1'b1;
            idle_consume = 1'b0;
            idle_mode    = MODE_HALT;
        end
    end

    // Main decode for the current mode.
    always_comb begin
        mode_next = mode_reg;
        consume   = 1'b0;
        res_count = 2'd0;
        res0      = mk_result(OUT_DONE, TK_ERROR, 8'h00, line_sat, col_sat);
        res1      = mk_result(OUT_DONE, TK_ERROR, 8'h00, line_sat, col_sat);
        unique case (mode_reg)
            MODE_IDLE, MODE_SYMBOL, MODE_COMMENT, MODE_STRING, MODE_ESCAPE: begin
                if (beat.end_mark) begin
                    if (mode_reg == MODE_SYMBOL) begin
                        res0      = mk_result(OUT_DONE, TK_SYMBOL, 8'h00, line_sat, col_sat);
                        res1      = mk_result(OUT_DONE, TK_END, 8'h00, line_sat, col_sat);
                        res_count = 2'd2;
                        mode_next = MODE_IDLE;
                    end else if ((mode_reg == MODE_STRING) || (mode_reg == MODE_ESCAPE)) begin
                        res_count = 2'd1;
                        mode_next = MODE_HALT;
                    end else begin
                        res0      = mk_result(OUT_DONE, TK_END, 8'h00, line_sat, col_sat);
                        res_count = 2'd1;
                        mode_next = MODE_IDLE;
                    end
                end else if (mode_reg == MODE_COMMENT) begin
                    consume = 1'b1;
                    if (ch == CH_LF) begin
                        mode_next = MODE_IDLE;
                    end
                end else if (mode_reg == MODE_STRING) begin
                    consume = 1'b1;
                    if (ch == CH_QUOTE) begin
                        res0      = mk_result(OUT_DONE, TK_STRING, 8'h00, line_sat, col_sat);
                        res_count = 2'd1;
                        mode_next = MODE_IDLE;
                    end else if (ch == CH_BACKSLASH) begin
                        mode_next = MODE_ESCAPE;
                    end else begin
                        res0      = mk_result(OUT_TEXT, TK_STRING, ch, line_sat, col_sat);
                        res_count = 2'd1;
                    end
                end else if (mode_reg == MODE_ESCAPE) begin
                    res_count = 2'd1;
                    if ((ch == CH_QUOTE) || (ch == CH_BACKSLASH) || (ch == CH_LOWER_N)) begin
                        res0 = mk_result(OUT_TEXT, TK_STRING,
                                         (ch == CH_LOWER_N) ? CH_LF : ch, line_sat, col_sat);
                        consume   = 1'b1;
                        mode_next = MODE_STRING;
                    end else begin
                        mode_next = MODE_HALT;
                    end
                end else if ((mode_reg == MODE_SYMBOL) && (is_letter(ch) || is_digit(ch))) begin
                    res0      = mk_result(OUT_TEXT, TK_SYMBOL, ch, line_sat, col_sat);
                    res_count = 2'd1;
                    consume   = 1'b1;
                end else if (mode_reg == MODE_SYMBOL) begin
                    // Symbol closed by this character, which is then scanned afresh.
                    res0      = mk_result(OUT_DONE, TK_SYMBOL, 8'h00, line_sat, col_sat);
                    res1      = idle_res;
                    res_count = idle_emit ? 2'd2 : 2'd1;
                    consume   = idle_consume;
                    mode_next = idle_mode;
                end else begin
                    res0      = idle_res;
                    res_count = idle_emit ? 2'd1 : 2'd0;
                    consume   = idle_consume;
                    mode_next = idle_mode;
                end
            end
            default: begin
                // Halted: every beat reports an error and nothing moves.
                res_count = 2'd1;
            end
        endcase

        if (res_count == 2'd1) begin
            res0.last_result = 1'b1;
        end
        if (res_count == 2'd2) begin
            res1.last_result = 1'b1;
        end
    end

    // Line and column counters, both saturating.
    always_comb begin
        line_next = line_reg;
        col_next  = col_reg;
        if (consume) begin
            if (ch == CH_LF) begin
                if (line_reg != {LINE_WIDTH{1'b1}}) begin
                    line_next = line_reg + LINE_WIDTH'(1);
                end
                col_next = '0;
            end else if (col_reg != {COLUMN_WIDTH{1'b1}}) begin
                col_next = col_reg + COLUMN_WIDTH'(1);
            end
        end
    end

    // State registers move only when a beat leaves the input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
            line_reg <= '0;
            col_reg  <= '0;
        end else if (advance) begin
            mode_reg <= mode_next;
            line_reg <= line_next;
            col_reg  <= col_next;
        end
    end

    assign push.count  = advance ? res_count : 2'd0;
    assign push.first  = res0;
    assign push.second = res1;

endmodule

// ===== src/gtt_outq.sv =====
// Result queue: takes up to two result beats a cycle and releases one while m_ready is high.
module gtt_outq (
    input  logic             aclk,
    input  logic             aresetn,
    input  gtt_pkg::push_t   push,
    output logic             room,
    output logic             m_valid,
    input  logic             m_ready,
    output gtt_pkg::result_t m_data
);
    import gtt_pkg::*;

    result_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_IDX_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_IDX_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   pop;
    logic [QUEUE_IDX_W-1:0] wr_ptr_plus1;

    assign pop          = m_valid && m_ready;
    assign wr_ptr_plus1 = wr_ptr_reg + QUEUE_IDX_W'(1);

    // Room for the worst case of two new beats, ignoring a pop in the same cycle.
    assign room    = (count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH - 2));
    assign m_valid = (count_reg != '0);
    assign m_data  = entry_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping.
    always_comb begin
        wr_ptr_next = wr_ptr_reg + QUEUE_IDX_W'(push.count);
        rd_ptr_next = pop ? rd_ptr_reg + QUEUE_IDX_W'(1) : rd_ptr_reg;
        count_next  = count_reg + QUEUE_CNT_W'(push.count) - QUEUE_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage; the second beat lands in the slot after the first.
    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            entry_reg[wr_ptr_plus1] <= push.second;
        end
    end

`ifndef SYNTHESIS
    a_fill_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH))
        else $error("result queue fill exceeds its depth");

    a_push_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.count != 2'd0) |-> (QUEUE_CNT_W'(push.count) <= QUEUE_CNT_W'(QUEUE_DEPTH) - count_reg))
        else $error("result beats pushed into a full queue");

    a_push_count_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        push.count != 2'd3)
        else $error("scanner produced more than two results for one beat");

    a_pop_then_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && (push.count == 2'd0)) |=> (rd_ptr_reg == $past(rd_ptr_reg) + QUEUE_IDX_W'(1)))
        else $error("read pointer failed to advance after a pop");
`endif

endmodule

// ===== src/grammar_text_tokenizer_core.sv =====
// Top level of the grammar text tokenizer: input register, scanner and result queue.
//
// Each accepted character beat is held in an input register and scanned once the queue has
// room for its results; the results (none, one or two) go into a four-entry queue that
// feeds the result channel one beat per cycle while m_ready is high, so the first result of
// a beat is offered after it has passed the input register and entered the queue.
// A new character can be taken every cycle as long as the queue has room for two
// more beats; the result port's one-beat-per-cycle drain is what sets the sustained rate
// when beats produce two results. Symbol and string text leaves byte by byte, followed by a
// token-complete beat; after an error the scanner reports ERROR for every further beat until
// reset. Line and column counters are LINE_WIDTH and COLUMN_WIDTH bits wide and saturate.
module grammar_text_tokenizer_core #(
    parameter int unsigned LINE_WIDTH   = 16,
    parameter int unsigned COLUMN_WIDTH = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  gtt_pkg::input_t  s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output gtt_pkg::result_t m_data
);
    import gtt_pkg::*;

    input_t in_reg;
    logic   in_valid_reg, in_valid_next;
    logic   advance;
    logic   room;
    push_t  push;

    // A held beat moves on when the queue can take its results.
    assign advance       = in_valid_reg && room;
    assign s_ready       = !in_valid_reg || advance;
    assign in_valid_next = (s_valid && s_ready) || (in_valid_reg && !advance);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    // Input payload register.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    gtt_scan #(
        .LINE_WIDTH   (LINE_WIDTH),
        .COLUMN_WIDTH (COLUMN_WIDTH)
    ) u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .beat    (in_reg),
        .push    (push)
    );

    gtt_outq u_outq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .room    (room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

`ifndef SYNTHESIS
    a_held_beat_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_reg)))
        else $error("input register lost or changed a stalled beat");

    a_push_only_on_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.count != 2'd0) |-> advance)
        else $error("results pushed without a beat leaving the input register");

    a_last_marked: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.count == 2'd2) |-> (!push.first.last_result && push.second.last_result))
        else $error("final-result mark misplaced on a two-result beat");
`endif

endmodule
